>>> rtl/es2c_pkg.sv
`default_nettype none
package es2c_pkg;

  localparam int SECONDS_BITS = 32;
  localparam int IN_W         = 32;
  localparam int DAYS_W       = SECONDS_BITS - 16;
  localparam int DIV_REM_W    = 17;
  localparam int SUB_W        = (DAYS_W > DIV_REM_W + 1) ? DAYS_W : DIV_REM_W + 1;
  localparam int YEAR_W       = 12;
  localparam int HREM_W       = 12;

  // 86400 = 675 << 7: scale the count down by 128, then multiply by the reciprocal of 675
  localparam int DAY_PRE_SHIFT = 7;
  localparam int MUL_A_W       = SECONDS_BITS - DAY_PRE_SHIFT;
  localparam int MUL_B_W       = MUL_A_W + 1;
  localparam int MUL_P_W       = MUL_A_W + MUL_B_W;
  localparam int DAY_SHIFT     = MUL_A_W + 10;
  localparam longint unsigned DAY_RECIP_FULL = ((64'd1 << DAY_SHIFT) + 64'd674) / 64'd675;
  localparam logic [MUL_B_W-1:0] DAY_RECIP = MUL_B_W'(DAY_RECIP_FULL);

  localparam int          HOUR_PRE_SHIFT = 4;
  localparam int          HOUR_SHIFT     = 21;
  localparam logic [13:0] HOUR_RECIP     = 14'd9321;
  localparam int          MIN_PRE_SHIFT  = 2;
  localparam int          MIN_SHIFT      = 14;
  localparam logic [10:0] MIN_RECIP      = 11'd1093;

  localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
  localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
  localparam logic [16:0] SECS_PER_MIN  = 17'd60;

  localparam logic [YEAR_W-1:0] BASE_YEAR = YEAR_W'(1970);
  localparam logic [1:0] BASE_MOD4   = 2'd2;
  localparam logic [6:0] BASE_MOD100 = 7'd70;
  localparam logic [8:0] BASE_MOD400 = 9'd370;

  localparam logic [8:0] YEAR_DAYS      = 9'd365;
  localparam logic [8:0] LEAP_YEAR_DAYS = 9'd366;

  localparam logic [3:0] MON_FEB = 4'd1;
  localparam logic [3:0] MON_APR = 4'd3;
  localparam logic [3:0] MON_JUN = 4'd5;
  localparam logic [3:0] MON_SEP = 4'd8;
  localparam logic [3:0] MON_NOV = 4'd10;
  localparam logic [3:0] MON_DEC = 4'd11;

  typedef struct packed {
    logic             ge;
    logic [SUB_W-1:0] diff;
  } es2c_sub_res_t;

  function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
    logic [4:0] len;
    len = 5'd31;
    if (mon == MON_FEB) begin
      len = leap ? 5'd29 : 5'd28;
    end else if (mon == MON_APR || mon == MON_JUN || mon == MON_SEP || mon == MON_NOV) begin
      len = 5'd30;
    end
    return len;
  endfunction

endpackage
`default_nettype wire

>>> rtl/es2c_sub.sv
`default_nettype none
module es2c_sub (
  input  logic [es2c_pkg::SUB_W-1:0] a_i,
  input  logic [es2c_pkg::SUB_W-1:0] b_i,
  output es2c_pkg::es2c_sub_res_t    res_o
);

  logic                      borrow;
  logic [es2c_pkg::SUB_W-1:0] diff;

  assign {borrow, diff} = {1'b0, a_i} - {1'b0, b_i};
  assign res_o.ge       = ~borrow;
  assign res_o.diff     = diff;

endmodule
`default_nettype wire

>>> rtl/epoch_seconds_to_calendar_core.sv
// Flow: setup steps S_DAY, S_SOD, S_HOUR, S_HREM, S_MIN and S_SEC split the count with one
//   shared multiplier (reciprocals of 86400, 3600 and 60, and those constants) and one shared
//   subtractor, then one year step per whole year from 1970 (up to 136 plus the exit compare)
//   and one per whole month (up to 11 plus exit); S_DONE stalls while out_ready holds the last result.
// Throughput: one item at a time; in_ready is high only in idle.
// Reset: synchronous active-low rst_n clears the sequencer and out_valid.
`default_nettype none
module epoch_seconds_to_calendar_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [es2c_pkg::IN_W-1:0]      in_epoch_seconds,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [5:0]                     out_second,
  output logic [5:0]                     out_minute,
  output logic [4:0]                     out_hour,
  output logic [4:0]                     out_day_of_month,
  output logic [3:0]                     out_month_number,
  output logic [es2c_pkg::YEAR_W-1:0]    out_year_number
);

  localparam int SB = es2c_pkg::SECONDS_BITS;
  localparam int RW = es2c_pkg::DIV_REM_W;
  localparam int HW = es2c_pkg::HREM_W;
  localparam int AW = es2c_pkg::MUL_A_W;
  localparam int BW = es2c_pkg::MUL_B_W;
  localparam int PW = es2c_pkg::MUL_P_W;
  localparam int DW = es2c_pkg::DAYS_W;
  localparam int XW = es2c_pkg::SUB_W;

  typedef enum logic [3:0] {
    S_IDLE, S_DAY, S_SOD, S_HOUR, S_HREM, S_MIN, S_SEC, S_YEAR, S_MONTH, S_DONE
  } state_t;

  state_t                          state_r;
  logic [SB-1:0]                   secs_r;
  logic [DW-1:0]                   days_r;
  logic [RW-1:0]                   sod_r;
  logic [HW-1:0]                   hrem_r;
  logic [4:0]                      hour_r;
  logic [5:0]                      minute_r;
  logic [5:0]                      second_r;
  logic [es2c_pkg::YEAR_W-1:0]     year_r;
  logic [1:0]                      m4_r;
  logic [6:0]                      m100_r;
  logic [8:0]                      m400_r;
  logic [3:0]                      mon_r;
  logic                            out_valid_r;
  logic [5:0]                      out_second_r;
  logic [5:0]                      out_minute_r;
  logic [4:0]                      out_hour_r;
  logic [4:0]                      out_day_r;
  logic [3:0]                      out_month_r;
  logic [es2c_pkg::YEAR_W-1:0]     out_year_r;

  logic [AW-1:0]                   mul_a;
  logic [BW-1:0]                   mul_b;
  logic [PW-1:0]                   prod;
  logic                            leap;
  logic [4:0]                      mlen;
  logic [XW-1:0]                   sub_a;
  logic [XW-1:0]                   sub_b;
  es2c_pkg::es2c_sub_res_t         sub_res;

  assign prod = PW'(mul_a) * PW'(mul_b);
  assign leap = ((m4_r == 2'd0) && (m100_r != 7'd0)) || (m400_r == 9'd0);
  assign mlen = es2c_pkg::month_len(mon_r, leap);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_DAY: begin
        mul_a = secs_r[SB-1:es2c_pkg::DAY_PRE_SHIFT];
        mul_b = es2c_pkg::DAY_RECIP;
      end
      S_SOD: begin
        mul_a = AW'(days_r);
        mul_b = BW'(es2c_pkg::SECS_PER_DAY);
      end
      S_HOUR: begin
        mul_a = AW'(sod_r[RW-1:es2c_pkg::HOUR_PRE_SHIFT]);
        mul_b = BW'(es2c_pkg::HOUR_RECIP);
      end
      S_HREM: begin
        mul_a = AW'(hour_r);
        mul_b = BW'(es2c_pkg::SECS_PER_HOUR);
      end
      S_MIN: begin
        mul_a = AW'(hrem_r[HW-1:es2c_pkg::MIN_PRE_SHIFT]);
        mul_b = BW'(es2c_pkg::MIN_RECIP);
      end
      S_SEC: begin
        mul_a = AW'(minute_r);
        mul_b = BW'(es2c_pkg::SECS_PER_MIN);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    sub_a = '0;
    sub_b = '0;
    unique case (state_r)
      S_SOD: begin
        sub_a = XW'(secs_r[RW-1:0]);
        sub_b = XW'(prod[RW-1:0]);
      end
      S_HREM: begin
        sub_a = XW'(sod_r);
        sub_b = XW'(prod[RW-1:0]);
      end
      S_SEC: begin
        sub_a = XW'(hrem_r);
        sub_b = XW'(prod[HW-1:0]);
      end
      S_YEAR: begin
        sub_a = XW'(days_r);
        sub_b = XW'(leap ? es2c_pkg::LEAP_YEAR_DAYS : es2c_pkg::YEAR_DAYS);
      end
      S_MONTH: begin
        sub_a = XW'(days_r);
        sub_b = XW'(mlen);
      end
      default: begin
      end
    endcase
  end

  es2c_sub u_sub (
    .a_i   (sub_a),
    .b_i   (sub_b),
    .res_o (sub_res)
  );

  assign in_ready         = (state_r == S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_second       = out_second_r;
  assign out_minute       = out_minute_r;
  assign out_hour         = out_hour_r;
  assign out_day_of_month = out_day_r;
  assign out_month_number = out_month_r;
  assign out_year_number  = out_year_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            secs_r  <= SB'(in_epoch_seconds);
            state_r <= S_DAY;
          end
        end
        S_DAY: begin
          days_r  <= prod[es2c_pkg::DAY_SHIFT +: DW];
          state_r <= S_SOD;
        end
        S_SOD: begin
          sod_r   <= sub_res.diff[RW-1:0];
          state_r <= S_HOUR;
        end
        S_HOUR: begin
          hour_r  <= prod[es2c_pkg::HOUR_SHIFT +: 5];
          state_r <= S_HREM;
        end
        S_HREM: begin
          hrem_r  <= sub_res.diff[HW-1:0];
          state_r <= S_MIN;
        end
        S_MIN: begin
          minute_r <= prod[es2c_pkg::MIN_SHIFT +: 6];
          state_r  <= S_SEC;
        end
        S_SEC: begin
          second_r <= sub_res.diff[5:0];
          year_r   <= es2c_pkg::BASE_YEAR;
          m4_r     <= es2c_pkg::BASE_MOD4;
          m100_r   <= es2c_pkg::BASE_MOD100;
          m400_r   <= es2c_pkg::BASE_MOD400;
          state_r  <= S_YEAR;
        end
        S_YEAR: begin
          if (sub_res.ge) begin
            days_r <= DW'(sub_res.diff);
            year_r <= year_r + 1'b1;
            m4_r   <= m4_r + 1'b1;
            m100_r <= (m100_r == 7'd99) ? 7'd0 : m100_r + 1'b1;
            m400_r <= (m400_r == 9'd399) ? 9'd0 : m400_r + 1'b1;
          end else begin
            mon_r   <= '0;
            state_r <= S_MONTH;
          end
        end
        S_MONTH: begin
          if (!sub_res.ge || mon_r == es2c_pkg::MON_DEC) begin
            state_r <= S_DONE;
          end else begin
            days_r <= DW'(sub_res.diff);
            mon_r  <= mon_r + 1'b1;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_second_r <= second_r;
            out_minute_r <= minute_r;
            out_hour_r   <= hour_r;
            out_day_r    <= days_r[4:0] + 5'd1;
            out_month_r  <= mon_r + 4'd1;
            out_year_r   <= year_r;
            out_valid_r  <= 1'b1;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  a_accept_starts_day: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_DAY))
    else $error("accepted beat did not start the day split");

  a_leap_counters: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_YEAR || state_r == S_MONTH) |->
      (m4_r == m100_r[1:0] && m4_r == m400_r[1:0] && m4_r == year_r[1:0]))
    else $error("leap counters out of step with year");

  a_sod_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_HOUR || state_r == S_HREM) |-> (sod_r < es2c_pkg::SECS_PER_DAY))
    else $error("second of day out of range");

  a_hrem_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MIN || state_r == S_SEC) |-> (RW'(hrem_r) < es2c_pkg::SECS_PER_HOUR))
    else $error("second of hour out of range");

  a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MONTH) |-> (mon_r <= es2c_pkg::MON_DEC))
    else $error("month index out of range");

  a_out_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_day_r != 5'd0 && out_month_r != 4'd0 && out_month_r <= 4'd12))
    else $error("result day or month out of range");

endmodule
`default_nettype wire

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
module tb;

  localparam int NUM_DIRECTED = 25;
  localparam int NUM_RANDOM   = 1030;
  localparam int CYCLE_LIMIT  = 1500000;
  localparam int DRAIN_CYCLES = 400;
  localparam int unsigned DAY_SECS = 86400;

  typedef struct packed {
    logic [5:0]                  second;
    logic [5:0]                  minute;
    logic [4:0]                  hour;
    logic [4:0]                  day_of_month;
    logic [3:0]                  month_number;
    logic [es2c_pkg::YEAR_W-1:0] year_number;
  } calendar_t;

  typedef struct packed {
    logic [es2c_pkg::IN_W-1:0] seconds;
    logic                      pinned;
    calendar_t                 want;
  } stim_row_t;

  localparam stim_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
    '{32'd0,          1'b1, '{6'd0, 6'd0, 5'd0, 5'd1, 4'd1, 12'd1970}},
    '{32'hFFFF_FFFF,  1'b1, '{6'd15, 6'd28, 5'd6, 5'd7, 4'd2, 12'd2106}},
    '{32'd59,         1'b0, '0},
    '{32'd60,         1'b0, '0},
    '{32'd3599,       1'b0, '0},
    '{32'd3600,       1'b0, '0},
    '{32'd86399,      1'b0, '0},
    '{32'd86400,      1'b0, '0},
    '{32'd2678399,    1'b0, '0},
    '{32'd2678400,    1'b0, '0},
    '{32'd31535999,   1'b0, '0},
    '{32'd31536000,   1'b0, '0},
    '{32'd951782399,  1'b0, '0},
    '{32'd951782400,  1'b0, '0},
    '{32'd951868800,  1'b0, '0},
    '{32'd978307199,  1'b0, '0},
    '{32'd978307200,  1'b0, '0},
    '{32'd2147483647, 1'b0, '0},
    '{32'd2147483648, 1'b0, '0},
    '{32'd4102444799, 1'b0, '0},
    '{32'd4102444800, 1'b0, '0},
    '{32'd4107542399, 1'b0, '0},
    '{32'd4107542400, 1'b0, '0},
    '{32'h5555_5555,  1'b0, '0},
    '{32'hAAAA_AAAA,  1'b0, '0}
  };

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic [es2c_pkg::IN_W-1:0]     in_epoch_seconds = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [5:0]                    out_second;
  logic [5:0]                    out_minute;
  logic [4:0]                    out_hour;
  logic [4:0]                    out_day_of_month;
  logic [3:0]                    out_month_number;
  logic [es2c_pkg::YEAR_W-1:0]   out_year_number;

  calendar_t   pending_dates [$];
  int unsigned error_count = 0;
  int unsigned checked_count = 0;
  int unsigned sent_count = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  epoch_seconds_to_calendar_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_epoch_seconds (in_epoch_seconds),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_second       (out_second),
    .out_minute       (out_minute),
    .out_hour         (out_hour),
    .out_day_of_month (out_day_of_month),
    .out_month_number (out_month_number),
    .out_year_number  (out_year_number)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic bit is_leap(int unsigned yr);
    return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
  endfunction

  function automatic int unsigned days_in_month(logic [3:0] mon, bit leap);
    if (mon == es2c_pkg::MON_FEB) begin
      return leap ? 29 : 28;
    end
    if (mon == es2c_pkg::MON_APR || mon == es2c_pkg::MON_JUN ||
        mon == es2c_pkg::MON_SEP || mon == es2c_pkg::MON_NOV) begin
      return 30;
    end
    return 31;
  endfunction

  function automatic calendar_t calendar_of(logic [es2c_pkg::IN_W-1:0] secs);
    calendar_t       c;
    longint unsigned days;
    int unsigned     sod;
    int unsigned     yr;
    int unsigned     mon;
    int unsigned     span;
    days = secs / DAY_SECS;
    sod  = secs % DAY_SECS;
    yr   = 1970;
    span = is_leap(yr) ? 366 : 365;
    while (days >= span) begin
      days -= span;
      yr++;
      span = is_leap(yr) ? 366 : 365;
    end
    mon  = 0;
    span = days_in_month(4'(mon), is_leap(yr));
    while (days >= span && mon < 11) begin
      days -= span;
      mon++;
      span = days_in_month(4'(mon), is_leap(yr));
    end
    c.second       = 6'(sod % 60);
    c.minute       = 6'((sod % 3600) / 60);
    c.hour         = 5'(sod / 3600);
    c.day_of_month = 5'(days + 1);
    c.month_number = 4'(mon + 1);
    c.year_number  = es2c_pkg::YEAR_W'(yr);
    return c;
  endfunction

  function automatic longint unsigned month_start_day(int unsigned yr, int unsigned mon);
    longint unsigned d;
    int unsigned     y;
    int unsigned     m;
    d = 0;
    for (y = 1970; y < yr; y++) d += is_leap(y) ? 366 : 365;
    for (m = 0; m < mon; m++) d += days_in_month(4'(m), is_leap(yr));
    return d;
  endfunction

  function automatic logic [es2c_pkg::IN_W-1:0] random_seconds();
    int unsigned     kind;
    int unsigned     yr;
    int unsigned     mon;
    longint unsigned base;
    kind = $urandom_range(9);
    if (kind == 4) begin
      base = longint'($urandom_range(49709)) * DAY_SECS;
      return es2c_pkg::IN_W'(base + $urandom_range(4) - 2);
    end
    if (kind == 5 || kind == 6) begin
      if (kind == 5) begin
        yr  = $urandom_range(2105, 1970);
        mon = $urandom_range(11);
      end else begin
        yr  = 1972 + 4 * $urandom_range(33);
        mon = $urandom_range(2, 1);
      end
      base = month_start_day(yr, mon) * DAY_SECS;
      return es2c_pkg::IN_W'(base + $urandom_range(2) - 1);
    end
    if (kind == 7) begin
      return es2c_pkg::IN_W'($urandom_range(200000));
    end
    return es2c_pkg::IN_W'($urandom);
  endfunction

  function automatic void check_field(string name, logic [es2c_pkg::YEAR_W-1:0] want,
                                      logic [es2c_pkg::YEAR_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endfunction

  task automatic send_beat(input logic [es2c_pkg::IN_W-1:0] secs, input bit pinned,
                           input calendar_t want);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_epoch_seconds <= secs;
    do @(posedge clk); while (!in_ready);
    pending_dates.push_back(pinned ? want : calendar_of(secs));
    sent_count++;
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin : result_check
    calendar_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_dates.size() == 0) begin
        $error("result beat with no date pending");
        error_count++;
      end else begin
        want = pending_dates.pop_front();
        check_field("second", es2c_pkg::YEAR_W'(want.second),
                    es2c_pkg::YEAR_W'(out_second));
        check_field("minute", es2c_pkg::YEAR_W'(want.minute),
                    es2c_pkg::YEAR_W'(out_minute));
        check_field("hour", es2c_pkg::YEAR_W'(want.hour),
                    es2c_pkg::YEAR_W'(out_hour));
        check_field("day_of_month", es2c_pkg::YEAR_W'(want.day_of_month),
                    es2c_pkg::YEAR_W'(out_day_of_month));
        check_field("month_number", es2c_pkg::YEAR_W'(want.month_number),
                    es2c_pkg::YEAR_W'(out_month_number));
        check_field("year_number", want.year_number, out_year_number);
        checked_count++;
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d dates pending", cycle_count, pending_dates.size());
    $display("** epoch_seconds_to_calendar_core: FAILED **");
    $finish;
  end

  initial begin : stimulus
    int unsigned total;
    int unsigned idx;
    int unsigned phase;
    total = NUM_DIRECTED + NUM_RANDOM;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    for (idx = 0; idx < total; idx++) begin
      phase = idx * 3 / total;
      case (phase)
        0: begin
          send_idle_pct = 24;
          recv_idle_pct = 84;
        end
        1: begin
          send_idle_pct = 84;
          recv_idle_pct = 24;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      if (idx < NUM_DIRECTED) begin
        send_beat(DIRECTED_ROWS[idx].seconds, DIRECTED_ROWS[idx].pinned,
                  DIRECTED_ROWS[idx].want);
      end else begin
        send_beat(random_seconds(), 1'b0, '0);
      end
    end
    in_valid <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d epoch counts converted (%0d directed), %0d results compared",
             sent_count, NUM_DIRECTED, checked_count);
    $display("covered: both idle mixes, full rate, range ends, leap days, month and year turns");
    if (error_count == 0) begin
      $display("** epoch_seconds_to_calendar_core: PASSED **");
    end else begin
      $display("** epoch_seconds_to_calendar_core: FAILED **");
    end
    $finish;
  end

endmodule
